FILE: sv/assert_macros.svh
// assertion macros used by the framed_packet_parser_unit rtl file of the framed packet parser
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define FPP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent must hold on the clock edge after the antecedent
`define FPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FPP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/fpp_pkg.sv
// framed packet parser package: transfer types, codes, constants, crc step
// no dependencies; imported by fpp_cfg and framed_packet_parser_unit
`default_nettype none

package fpp_pkg;

  // default sizes
  localparam int MAX_PAYLOAD_DEF  = 64;
  localparam int BUFFER_DEPTH_DEF = 128;
  localparam int QUEUE_DEPTH_DEF  = 8;

  // frame layout
  localparam int HEADER_LEN   = 12;
  localparam int OVERHEAD_LEN = 14;
  localparam logic [7:0] SYNC_0        = 8'hA5;
  localparam logic [7:0] SYNC_1        = 8'h5A;
  localparam logic [7:0] FRAME_VERSION = 8'h01;
  localparam logic [7:0] ROLE_MIN      = 8'h01;
  localparam logic [7:0] ROLE_MAX      = 8'h02;

  // crc-16/ccitt-false
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // request codes
  localparam logic [1:0] FUNC_RX    = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_COUNT = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_FRAME   = 2'd0;
  localparam logic [1:0] KIND_REFUSED = 2'd1;
  localparam logic [1:0] KIND_COUNTER = 2'd2;
  localparam logic [1:0] KIND_CLEARED = 2'd3;

  // event counters
  localparam int NUM_COUNTERS = 7;
  localparam int CNT_VERSION  = 0;
  localparam int CNT_LENGTH   = 1;
  localparam int CNT_CRC      = 2;
  localparam int CNT_UNKNOWN  = 3;
  localparam int CNT_OVERFLOW = 4;
  localparam int CNT_VALID    = 5;
  localparam int CNT_TIMEOUT  = 6;

  // configuration registers
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_ID_A    = 3'd1;
  localparam logic [2:0] REG_ID_B    = 3'd2;
  localparam logic [2:0] REG_ID_C    = 3'd3;
  localparam logic [2:0] REG_ID_D    = 3'd4;
  localparam logic [31:0] TIMEOUT_RST = 32'd100;
  localparam logic [15:0] ID_A_RST    = 16'd1;
  localparam logic [15:0] ID_B_RST    = 16'd2;
  localparam logic [15:0] ID_C_RST    = 16'd3;
  localparam logic [15:0] ID_D_RST    = 16'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic [7:0]  capacity;
    logic [2:0]  counter_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  sender_role;
    logic [15:0] message_id;
    logic [31:0] sequence_res;
    logic [31:0] receive_ms;
    logic [6:0]  payload_size;
    logic [7:0]  payload_byte;
    logic        last;
    logic [31:0] counter_value;
  } out_t;

  typedef struct packed {
    logic [31:0] timeout_ms;
    logic [15:0] known_id_a;
    logic [15:0] known_id_b;
    logic [15:0] known_id_c;
    logic [15:0] known_id_d;
  } cfg_t;

  // one byte of crc, msb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fpp_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`default_nettype none

module fpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/fpp_cfg.sv
// apb configuration registers: timeout and the four known message ids
// depends on fpp_pkg
`default_nettype none

module fpp_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel_i,
  input  wire logic                            penable_i,
  input  wire logic                            pwrite_i,
  input  wire logic [fpp_pkg::CFG_ADDR_W-1:0]  paddr_i,
  input  wire logic [31:0]                     pwdata_i,
  output logic      [31:0]                     prdata_o,
  output logic                                 pready_o,
  output fpp_pkg::cfg_t                        cfg_o
);

  import fpp_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr_i[CFG_ADDR_W-1:2];
  assign wr_en   = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_TIMEOUT: cfg_d.timeout_ms = pwdata_i;
        REG_ID_A:    cfg_d.known_id_a = pwdata_i[15:0];
        REG_ID_B:    cfg_d.known_id_b = pwdata_i[15:0];
        REG_ID_C:    cfg_d.known_id_c = pwdata_i[15:0];
        REG_ID_D:    cfg_d.known_id_d = pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TIMEOUT: prdata_o = cfg_q.timeout_ms;
      REG_ID_A:    prdata_o = {16'h0000, cfg_q.known_id_a};
      REG_ID_B:    prdata_o = {16'h0000, cfg_q.known_id_b};
      REG_ID_C:    prdata_o = {16'h0000, cfg_q.known_id_c};
      REG_ID_D:    prdata_o = {16'h0000, cfg_q.known_id_d};
      default:     prdata_o = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{timeout_ms: TIMEOUT_RST, known_id_a: ID_A_RST, known_id_b: ID_B_RST,
                 known_id_c: ID_C_RST, known_id_d: ID_D_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

endmodule

`default_nettype wire

FILE: sv/framed_packet_parser_unit.sv
// receive: the scan reads each byte from the buffer ram in a read then a process state
// (each resync rereads from the new front); payload bytes pass to the frame queue ram
// by read then write states; pop reads then outputs each result; one request at a time
// the single read port of the receive buffer ram paces the scan
// reset clears all control state at once; the rams need no clearing pass
`default_nettype none
`include "assert_macros.svh"

module framed_packet_parser_unit #(
  parameter int MAX_PAYLOAD  = fpp_pkg::MAX_PAYLOAD_DEF,
  parameter int BUFFER_DEPTH = fpp_pkg::BUFFER_DEPTH_DEF,
  parameter int QUEUE_DEPTH  = fpp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire fpp_pkg::in_t                   in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output fpp_pkg::out_t                       out_data_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [fpp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  import fpp_pkg::*;

  localparam int PTR_W      = $clog2(BUFFER_DEPTH);
  localparam int FILL_W     = $clog2(BUFFER_DEPTH + 1);
  localparam int IDX_W      = $clog2(OVERHEAD_LEN + MAX_PAYLOAD);
  localparam int SZ_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int PMEM_DEPTH = QUEUE_DEPTH * MAX_PAYLOAD;
  localparam int PADDR_W    = (PMEM_DEPTH > 1) ? $clog2(PMEM_DEPTH) : 1;
  localparam int RX_W       = 40;

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_APPEND   = 4'd1;
  localparam logic [3:0] ST_SC_START = 4'd2;
  localparam logic [3:0] ST_SC_RD    = 4'd3;
  localparam logic [3:0] ST_SC_PROC  = 4'd4;
  localparam logic [3:0] ST_CP_SETUP = 4'd5;
  localparam logic [3:0] ST_CP_RD    = 4'd6;
  localparam logic [3:0] ST_CP_WR    = 4'd7;
  localparam logic [3:0] ST_POP_RD   = 4'd8;
  localparam logic [3:0] ST_POP_OUT  = 4'd9;
  localparam logic [3:0] ST_EMIT     = 4'd10;

  // circular add on the receive buffer
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [FILL_W-1:0] n);
    logic [PTR_W:0] s;
    s = (PTR_W+1)'(p) + (PTR_W+1)'(n);
    if (s >= (PTR_W+1)'(BUFFER_DEPTH)) begin
      s = s - (PTR_W+1)'(BUFFER_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [QPTR_W-1:0] q_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  cfg_t cfg;

  // control state
  logic [3:0]        state_q, state_d;
  logic              phase_q, phase_d;     // 0: rescan after a timeout cut, 1: after append
  logic              flag_q, flag_d;       // front byte dropped, start time to be reloaded
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [QPTR_W-1:0] q_head_q, q_head_d;
  logic [QCNT_W-1:0] q_count_q, q_count_d;
  logic [31:0]       partial_q, partial_d;
  logic [31:0]       cnt_q [NUM_COUNTERS];
  logic [31:0]       cnt_d [NUM_COUNTERS];
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SZ_W-1:0]   k_q, k_d;

  // working registers of the current request
  logic [7:0]        byte_q, byte_d;
  logic [31:0]       now_q, now_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        crc_lo_q, crc_lo_d;
  logic [7:0]        ver_q, ver_d;
  logic [7:0]        role_q, role_d;
  logic [15:0]       id_q, id_d;
  logic [15:0]       size_q, size_d;
  logic [31:0]       seq_q, seq_d;
  logic [31:0]       last_t_q, last_t_d;
  logic [QPTR_W-1:0] slot_q, slot_d;
  logic [1:0]        resp_kind_q, resp_kind_d;
  logic [31:0]       resp_cnt_q, resp_cnt_d;
  out_t              out_q, out_d;

  // queued frame headers, one entry per slot
  logic [1:0]        m_role_q [QUEUE_DEPTH];
  logic [15:0]       m_id_q   [QUEUE_DEPTH];
  logic [31:0]       m_seq_q  [QUEUE_DEPTH];
  logic [31:0]       m_time_q [QUEUE_DEPTH];
  logic [SZ_W-1:0]   m_size_q [QUEUE_DEPTH];
  logic              meta_we;
  logic [QPTR_W-1:0] meta_slot;

  // rams
  logic              rx_we;
  logic [PTR_W-1:0]  rx_waddr, rx_raddr;
  logic [RX_W-1:0]   rx_rdata;
  logic              pl_we;
  logic [PADDR_W-1:0] pl_waddr, pl_raddr;
  logic [7:0]        pl_rdata;

  // helpers
  logic              in_acc, out_free, timed_out, id_known, q_full;
  logic [7:0]        rx_b;
  logic [31:0]       rx_t, total32, fill32, idx32;
  logic [15:0]       crc_nx;
  logic [QPTR_W-1:0] qh_eff;
  logic [QCNT_W-1:0] qc_eff;
  logic [QPTR_W:0]   q_sum;
  logic [SZ_W-1:0]   cur_size, last_k;
  logic [NUM_COUNTERS-1:0] cnt_inc;
  logic              cnt_clr, do_drop, do_take, scan_done;

  fpp_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // received bytes with their arrival times, {time, byte}
  fpp_ram #(.WIDTH(RX_W), .DEPTH(BUFFER_DEPTH), .AW(PTR_W)) u_rx_ram (
    .clk_i     (clk_i),
    .wr_en_i   (rx_we),
    .wr_addr_i (rx_waddr),
    .wr_data_i ({now_q, byte_q}),
    .rd_addr_i (rx_raddr),
    .rd_data_o (rx_rdata)
  );

  // payloads of queued frames, MAX_PAYLOAD bytes per slot
  fpp_ram #(.WIDTH(8), .DEPTH(PMEM_DEPTH), .AW(PADDR_W)) u_pl_ram (
    .clk_i     (clk_i),
    .wr_en_i   (pl_we),
    .wr_addr_i (pl_waddr),
    .wr_data_i (rx_rdata[7:0]),
    .rd_addr_i (pl_raddr),
    .rd_data_o (pl_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rx_b    = rx_rdata[7:0];
  assign rx_t    = rx_rdata[RX_W-1:8];
  assign crc_nx  = crc_step(crc_q, rx_b);
  assign total32 = 32'(size_q) + 32'(OVERHEAD_LEN);
  assign fill32  = 32'(fill_q);
  assign idx32   = 32'(idx_q);

  // same read address serves the scan and the payload copy
  assign rx_raddr = ptr_add(head_q, FILL_W'(idx_q));
  assign rx_waddr = ptr_add(head_q, fill_q);

  assign pl_raddr = PADDR_W'(q_head_q) * PADDR_W'(MAX_PAYLOAD) + PADDR_W'(k_q);
  assign pl_waddr = PADDR_W'(slot_q) * PADDR_W'(MAX_PAYLOAD) + PADDR_W'(k_q);

  // a partial frame is stale when time went backwards or its age passed the limit
  assign timed_out = (fill_q != '0) &&
                     ((in_data_i.now_ms < partial_q) ||
                      ((in_data_i.now_ms - partial_q) > cfg.timeout_ms));

  assign id_known = (id_q == cfg.known_id_a) || (id_q == cfg.known_id_b) ||
                    (id_q == cfg.known_id_c) || (id_q == cfg.known_id_d);

  // ring slot for a new frame, oldest one evicted when full
  assign q_full = (q_count_q == QCNT_W'(QUEUE_DEPTH));
  assign qh_eff = q_full ? q_next(q_head_q) : q_head_q;
  assign qc_eff = q_full ? q_count_q - 1'b1 : q_count_q;
  assign q_sum  = (QPTR_W+1)'(qh_eff) + (QPTR_W+1)'(qc_eff);
  assign meta_slot = (q_sum >= (QPTR_W+1)'(QUEUE_DEPTH)) ?
                     QPTR_W'(q_sum - (QPTR_W+1)'(QUEUE_DEPTH)) : q_sum[QPTR_W-1:0];

  assign cur_size = m_size_q[q_head_q];
  assign last_k   = (cur_size == '0) ? '0 : cur_size - 1'b1;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    flag_d      = flag_q;
    fill_d      = fill_q;
    head_d      = head_q;
    q_head_d    = q_head_q;
    q_count_d   = q_count_q;
    partial_d   = partial_q;
    out_valid_d = out_valid_q && !out_ready_i;
    idx_d       = idx_q;
    k_d         = k_q;
    byte_d      = byte_q;
    now_d       = now_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    ver_d       = ver_q;
    role_d      = role_q;
    id_d        = id_q;
    size_d      = size_q;
    seq_d       = seq_q;
    last_t_d    = last_t_q;
    slot_d      = slot_q;
    resp_kind_d = resp_kind_q;
    resp_cnt_d  = resp_cnt_q;
    out_d       = out_q;
    rx_we       = 1'b0;
    pl_we       = 1'b0;
    meta_we     = 1'b0;
    cnt_inc     = '0;
    cnt_clr     = 1'b0;
    do_drop     = 1'b0;
    do_take     = 1'b0;
    scan_done   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          byte_d = in_data_i.rx_byte;
          now_d  = in_data_i.now_ms;
          case (in_data_i.func)
            FUNC_RX: begin
              if (timed_out) begin
                // cut the stale front byte and rescan before appending
                cnt_inc[CNT_TIMEOUT] = 1'b1;
                phase_d = 1'b0;
                do_drop = 1'b1;
              end else begin
                state_d = ST_APPEND;
              end
            end
            FUNC_POP: begin
              if ((q_count_q == '0) || (32'(in_data_i.capacity) < 32'(cur_size))) begin
                resp_kind_d = KIND_REFUSED;
                state_d     = ST_EMIT;
              end else begin
                k_d     = '0;
                state_d = ST_POP_RD;
              end
            end
            FUNC_COUNT: begin
              resp_kind_d = KIND_COUNTER;
              resp_cnt_d  = (32'(in_data_i.counter_index) < 32'(NUM_COUNTERS)) ?
                            cnt_q[in_data_i.counter_index] : 32'h0000_0000;
              state_d     = ST_EMIT;
            end
            default: begin
              fill_d      = '0;
              head_d      = '0;
              q_head_d    = '0;
              q_count_d   = '0;
              partial_d   = '0;
              flag_d      = 1'b0;
              cnt_clr     = 1'b1;
              resp_kind_d = KIND_CLEARED;
              state_d     = ST_EMIT;
            end
          endcase
        end
      end

      ST_APPEND: begin
        if (fill_q == '0) begin
          partial_d = now_q;
        end
        rx_we = 1'b1;
        if (fill_q == FILL_W'(BUFFER_DEPTH)) begin
          // buffer full: oldest byte gives way, new byte lands in its slot
          head_d = ptr_add(head_q, FILL_W'(1));
          flag_d = 1'b1;
          cnt_inc[CNT_LENGTH] = 1'b1;
        end else begin
          fill_d = fill_q + 1'b1;
        end
        phase_d = 1'b1;
        state_d = ST_SC_START;
      end

      ST_SC_START: begin
        if (fill_q == '0) begin
          scan_done = 1'b1;
        end else begin
          idx_d   = '0;
          crc_d   = CRC_INIT;
          state_d = ST_SC_RD;
        end
      end

      ST_SC_RD: begin
        state_d = ST_SC_PROC;
      end

      ST_SC_PROC: begin
        if ((idx_q == '0) && flag_q) begin
          partial_d = rx_t;
          flag_d    = 1'b0;
        end
        idx_d   = idx_q + 1'b1;
        state_d = ST_SC_RD;
        if (idx32 < 32'(HEADER_LEN)) begin
          crc_d = crc_nx;
          case (idx_q)
            IDX_W'(0): begin
              if (rx_b != SYNC_0) do_drop = 1'b1;
              else if (fill_q < FILL_W'(2)) scan_done = 1'b1;
            end
            IDX_W'(1): begin
              if (rx_b != SYNC_1) do_drop = 1'b1;
              else if (fill32 < 32'(HEADER_LEN)) scan_done = 1'b1;
            end
            IDX_W'(2):  ver_d         = rx_b;
            IDX_W'(3):  role_d        = rx_b;
            IDX_W'(4):  id_d[7:0]     = rx_b;
            IDX_W'(5):  id_d[15:8]    = rx_b;
            IDX_W'(6):  size_d[7:0]   = rx_b;
            IDX_W'(7):  size_d[15:8]  = rx_b;
            IDX_W'(8):  seq_d[7:0]    = rx_b;
            IDX_W'(9):  seq_d[15:8]   = rx_b;
            IDX_W'(10): seq_d[23:16]  = rx_b;
            IDX_W'(11): begin
              seq_d[31:24] = rx_b;
              if ((ver_q != FRAME_VERSION) || (role_q < ROLE_MIN) || (role_q > ROLE_MAX)) begin
                cnt_inc[CNT_VERSION] = 1'b1;
                do_drop = 1'b1;
              end else if (size_q > 16'(MAX_PAYLOAD)) begin
                cnt_inc[CNT_LENGTH] = 1'b1;
                do_drop = 1'b1;
              end else if (fill32 < total32) begin
                scan_done = 1'b1;
              end
            end
            default: ;
          endcase
        end else if (idx32 < total32 - 32'd2) begin
          crc_d = crc_nx;
        end else if (idx32 == total32 - 32'd2) begin
          crc_lo_d = rx_b;
        end else begin
          // closing crc byte
          last_t_d = rx_t;
          if ({rx_b, crc_lo_q} != crc_q) begin
            cnt_inc[CNT_CRC] = 1'b1;
            do_drop = 1'b1;
          end else if (id_known) begin
            state_d = ST_CP_SETUP;
          end else begin
            cnt_inc[CNT_UNKNOWN] = 1'b1;
            do_take = 1'b1;
          end
        end
      end

      ST_CP_SETUP: begin
        if (q_full) begin
          cnt_inc[CNT_OVERFLOW] = 1'b1;
        end
        cnt_inc[CNT_VALID] = 1'b1;
        meta_we   = 1'b1;
        q_head_d  = qh_eff;
        q_count_d = qc_eff + 1'b1;
        slot_d    = meta_slot;
        k_d       = '0;
        idx_d     = IDX_W'(HEADER_LEN);
        if (size_q == '0) begin
          do_take = 1'b1;
        end else begin
          state_d = ST_CP_RD;
        end
      end

      ST_CP_RD: begin
        state_d = ST_CP_WR;
      end

      ST_CP_WR: begin
        pl_we = 1'b1;
        if (32'(k_q) + 32'd1 == 32'(size_q)) begin
          do_take = 1'b1;
        end else begin
          k_d     = k_q + 1'b1;
          idx_d   = idx_q + 1'b1;
          state_d = ST_CP_RD;
        end
      end

      ST_POP_RD: begin
        state_d = ST_POP_OUT;
      end

      ST_POP_OUT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d              = '0;
          out_d.kind         = KIND_FRAME;
          out_d.sender_role  = m_role_q[q_head_q];
          out_d.message_id   = m_id_q[q_head_q];
          out_d.sequence_res = m_seq_q[q_head_q];
          out_d.receive_ms   = m_time_q[q_head_q];
          out_d.payload_size = 7'(cur_size);
          out_d.payload_byte = (cur_size == '0) ? 8'h00 : pl_rdata;
          out_d.last         = (k_q == last_k);
          if (k_q == last_k) begin
            q_head_d  = q_next(q_head_q);
            q_count_d = q_count_q - 1'b1;
            state_d   = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_POP_RD;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d               = '0;
          out_d.kind          = resp_kind_q;
          out_d.last          = 1'b1;
          out_d.counter_value = (resp_kind_q == KIND_COUNTER) ? resp_cnt_q : 32'h0000_0000;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // drop one byte at the front and restart the scan
    if (do_drop) begin
      head_d  = ptr_add(head_q, FILL_W'(1));
      fill_d  = fill_q - 1'b1;
      flag_d  = 1'b1;
      state_d = ST_SC_START;
    end

    // whole frame consumed
    if (do_take) begin
      head_d    = ptr_add(head_q, FILL_W'(total32));
      fill_d    = fill_q - FILL_W'(total32);
      partial_d = now_q;
      flag_d    = 1'b0;
      state_d   = ST_SC_START;
    end

    if (scan_done) begin
      if (!phase_q) begin
        partial_d = now_q;
        flag_d    = 1'b0;
        state_d   = ST_APPEND;
      end else begin
        state_d = ST_IDLE;
      end
    end

    for (int i = 0; i < NUM_COUNTERS; i++) begin
      cnt_d[i] = cnt_clr ? 32'h0000_0000 : cnt_q[i] + 32'(cnt_inc[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      flag_q      <= 1'b0;
      fill_q      <= '0;
      head_q      <= '0;
      q_head_q    <= '0;
      q_count_q   <= '0;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      flag_q      <= flag_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      q_head_q    <= q_head_d;
      q_count_q   <= q_count_d;
      partial_q   <= partial_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    now_q       <= now_d;
    crc_q       <= crc_d;
    crc_lo_q    <= crc_lo_d;
    ver_q       <= ver_d;
    role_q      <= role_d;
    id_q        <= id_d;
    size_q      <= size_d;
    seq_q       <= seq_d;
    last_t_q    <= last_t_d;
    slot_q      <= slot_d;
    resp_kind_q <= resp_kind_d;
    resp_cnt_q  <= resp_cnt_d;
    out_q       <= out_d;
    if (meta_we) begin
      m_role_q[meta_slot] <= role_q[1:0];
      m_id_q[meta_slot]   <= id_q;
      m_seq_q[meta_slot]  <= seq_q;
      m_time_q[meta_slot] <= last_t_q;
      m_size_q[meta_slot] <= SZ_W'(size_q);
    end
  end

  // buffer and queue occupancy stay within their depths
  `FPP_ASSERT(a_fill_bound, clk_i, rst_ni, 32'(fill_q) <= 32'(BUFFER_DEPTH), "buffer overfilled")
  `FPP_ASSERT(a_queue_bound, clk_i, rst_ni, 32'(q_count_q) <= 32'(QUEUE_DEPTH), "queue overfilled")
  // every accepted request leaves idle on the next edge
  `FPP_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, state_q != ST_IDLE, "accepted request left no work")
  // a pending start-time reload never outlives the scan while bytes remain
  `FPP_ASSERT(a_reload_settled, clk_i, rst_ni, (state_q != ST_IDLE) || !flag_q || (fill_q == '0), "start time reload left pending")

endmodule

`default_nettype wire
